@@ rtl/core/fsmf_pkg.sv @@
// ---------------------------------------------------------------------------
// fsmf_pkg
// Shared types and constants of the first substring match finder: window
// depth, position widths, configuration register indexes and cell control.
// ---------------------------------------------------------------------------
package fsmf_pkg;

  // window depth and the number of pattern bytes it can hold
  localparam int unsigned MaxPattern = 16;
  localparam int unsigned LenW       = 5;
  localparam int unsigned PatSelW    = 4;

  // text index range: position counter holds one more than the last index
  localparam int unsigned IdxW = 16;
  localparam int unsigned PosW = IdxW + 1;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPatLen  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStart   = 2'd3;

  // per-cell control: shift strobe, compare enable and aligned pattern byte
  typedef struct packed {
    logic       shift;
    logic       active;
    logic [7:0] pat_byte;
  } cell_ctrl_t;

endpackage

@@ rtl/core/fsmf_cell.sv @@
// ---------------------------------------------------------------------------
// fsmf_cell
// One window cell: holds one text byte, passes it to its neighbour on each
// shift and compares the byte entering it with its aligned pattern byte.
// ---------------------------------------------------------------------------
module fsmf_cell (
  input  logic                 clk_i,
  input  fsmf_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  output logic [7:0]           byte_o,
  output logic                 hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // shift in the neighbour's byte
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

  // the byte entering this cell is the new window byte at this place
  assign hit_o = !ctrl_i.active || (byte_i == ctrl_i.pat_byte);

endmodule

@@ rtl/core/first_substring_match_finder.sv @@
// ---------------------------------------------------------------------------
// first_substring_match_finder
// Streams one text byte per transaction through a row of window cells and
// reports the first position at or after a start index where the pattern
// begins.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: text_byte_i with end_of_text_i marking the final byte of a
//   string, qualified by in_valid_i and in_stall_o. Output channel: one
//   result (found_o, match_index_o, too_long_o) per string, qualified by
//   out_valid_o and out_stall_i. Configuration is written through cfg_we_i,
//   cfg_index_i and cfg_data_i while no string is in flight.
//   Throughput is one byte per cycle while in_stall_o is low: the window
//   shifts and all cells compare in the cycle a byte is taken. A string's
//   result appears from the output register the cycle after its last byte.
//   While the receiver stalls a pending result, in_stall_o is raised and the
//   result holds; a free output register never blocks the input side.
//   Reset clears the configuration registers, position, marks and the
//   pending result; after each final byte the per-string state returns to
//   the same cleared values while the configuration is kept.
// ---------------------------------------------------------------------------
module first_substring_match_finder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [fsmf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fsmf_pkg::CfgDataW-1:0]      cfg_data_i,
  // text input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         text_byte_i,
  input  logic                               end_of_text_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic [fsmf_pkg::IdxW-1:0]          match_index_o,
  output logic                               too_long_o
);

  localparam int unsigned N = fsmf_pkg::MaxPattern;

  // configuration registers
  logic [63:0]                 pat_low_q;
  logic [63:0]                 pat_high_q;
  logic [fsmf_pkg::LenW-1:0]   pat_len_q;
  logic [fsmf_pkg::IdxW-1:0]   start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      start_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fsmf_pkg::RegPatLow:  pat_low_q  <= cfg_data_i;
        fsmf_pkg::RegPatHigh: pat_high_q <= cfg_data_i;
        fsmf_pkg::RegPatLen:  pat_len_q  <= cfg_data_i[fsmf_pkg::LenW-1:0];
        fsmf_pkg::RegStart:   start_q    <= cfg_data_i[fsmf_pkg::IdxW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q;
  logic in_acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // per-string state
  logic [fsmf_pkg::PosW-1:0] pos_q, pos_d;
  logic                      ovf_q, ovf_d;
  logic                      found_q, found_d;
  logic [fsmf_pkg::IdxW-1:0] first_q, first_d;

  logic in_range;
  assign in_range = !pos_q[fsmf_pkg::PosW-1];

  // pattern bytes and length check
  logic [7:0] pat_bytes [N];
  logic       len_ok;

  always_comb begin
    for (int unsigned k = 0; k < N; k++) begin
      if (k < 8) begin
        pat_bytes[k] = pat_low_q[8*k +: 8];
      end else begin
        pat_bytes[k] = pat_high_q[8*(k-8) +: 8];
      end
    end
  end

  assign len_ok = (pat_len_q != '0) && (pat_len_q <= fsmf_pkg::LenW'(N));

  // cell control: window place j is compared with pattern byte len-1-j
  fsmf_pkg::cell_ctrl_t ctrl [N];

  always_comb begin
    logic [fsmf_pkg::LenW-1:0] sel;
    for (int unsigned j = 0; j < N; j++) begin
      sel              = pat_len_q - fsmf_pkg::LenW'(1) - fsmf_pkg::LenW'(j);
      ctrl[j].shift    = in_acc && in_range;
      ctrl[j].active   = len_ok && (fsmf_pkg::LenW'(j) < pat_len_q);
      ctrl[j].pat_byte = pat_bytes[sel[fsmf_pkg::PatSelW-1:0]];
    end
  end

  // row of window cells, newest byte enters cell 0
  logic [7:0] win [N+1];
  logic [N-1:0] hits;

  assign win[0] = text_byte_i;

  for (genvar j = 0; j < N; j++) begin : g_cell
    fsmf_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl[j]),
      .byte_i (win[j]),
      .byte_o (win[j+1]),
      .hit_o  (hits[j])
    );
  end

  // match begin index and window checks
  logic [fsmf_pkg::PosW-1:0] pos_inc;
  logic [fsmf_pkg::PosW-1:0] begin_idx;
  logic                      match;

  assign pos_inc   = pos_q + fsmf_pkg::PosW'(1);
  assign begin_idx = pos_inc - fsmf_pkg::PosW'(pat_len_q);
  assign match     = in_range && len_ok && !found_q && (&hits)
                   && (pos_inc >= fsmf_pkg::PosW'(pat_len_q))
                   && (begin_idx >= fsmf_pkg::PosW'(start_q));

  // next per-string state
  always_comb begin
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    found_d = found_q;
    first_d = first_q;
    if (in_acc) begin
      if (!in_range) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_inc;
        if (match) begin
          found_d = 1'b1;
          first_d = begin_idx[fsmf_pkg::IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ovf_q   <= 1'b0;
      found_q <= 1'b0;
      first_q <= '0;
    end else if (in_acc && end_of_text_i) begin
      pos_q   <= '0;
      ovf_q   <= 1'b0;
      found_q <= 1'b0;
      first_q <= '0;
    end else begin
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
      found_q <= found_d;
      first_q <= first_d;
    end
  end

  // output register
  logic                      res_found_q;
  logic [fsmf_pkg::IdxW-1:0] res_idx_q;
  logic                      res_long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && end_of_text_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && end_of_text_i) begin
      res_found_q <= found_d;
      res_idx_q   <= found_d ? first_d : '0;
      res_long_q  <= ovf_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_found_q;
  assign match_index_o = res_idx_q;
  assign too_long_o    = res_long_q;

endmodule
